FILE: hw/rtl/ps2_mouse_packet_decoder_macros.svh
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_DECODER_MACROS_SVH
`define PS2_MOUSE_PACKET_DECODER_MACROS_SVH

// same-cycle implication
`define PS2MPD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ps2mpd assertion failed");

// next-cycle implication
`define PS2MPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ps2mpd assertion failed");

`endif

FILE: hw/rtl/ps2mpd_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder package
// Event codes, status bit positions and the packet descriptor type.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2mpd_pkg;

  localparam logic [1:0] KIND_MOVE    = 2'd0;
  localparam logic [1:0] KIND_PRESS   = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  localparam int STAT_READY_BIT = 0;
  localparam int STAT_AUX_BIT   = 5;

  localparam logic [1:0] POS_LAST = 2'd2;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic              move;
    logic signed [8:0] dx;
    logic signed [9:0] dy;
    logic [2:0]        chg;
    logic [2:0]        now;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ps2_mouse_packet_decoder.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder
// Turns controller status/data words into movement and button events.
// ----------------------------------------------------------------------------
// The input side takes one word per cycle while in_stall is low; a word counts
// only when status bits 0 and 5 are both set. The third counted byte of a
// packet that moves or changes a button places one packet descriptor in a
// QUEUE_DEPTH-entry queue, and in_stall is high only while that queue is full.
// The event sequencer drains the queue and emits up to four events per packet
// (movement, then buttons left, right, middle) through a registered output,
// one per cycle unless out_stall holds it, out_last_event marking the final one.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_packet_decoder
  import ps2mpd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [7:0]   in_status_byte,
  input  wire logic [7:0]   in_data_byte,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [1:0]        out_event_kind,
  output logic signed [8:0] out_delta_x,
  output logic signed [9:0] out_delta_y,
  output logic [1:0]        out_button_index,
  output logic              out_last_event
);

  q_stat_t q_stat;
  desc_t   push_desc, pop_desc;
  logic    push, pop;

  ps2mpd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_status_byte (in_status_byte),
    .in_data_byte   (in_data_byte),
    .q_stat         (q_stat),
    .push           (push),
    .push_desc      (push_desc)
  );

  ps2mpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .q_stat    (q_stat)
  );

  ps2mpd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .pop_desc         (pop_desc),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_delta_x      (out_delta_x),
    .out_delta_y      (out_delta_y),
    .out_button_index (out_button_index),
    .out_last_event   (out_last_event)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/ps2mpd_front.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder front end
// Filters controller words, assembles three-byte packets, queues descriptors.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ps2_mouse_packet_decoder_macros.svh"

module ps2mpd_front
  import ps2mpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_status_byte,
  input  wire logic [7:0] in_data_byte,
  input  wire q_stat_t    q_stat,
  output logic            push,
  output desc_t           push_desc
);

  logic [1:0] pos_r, pos_nxt;
  logic [2:0] btn_r, btn_nxt;
  logic [7:0] byte0_r, byte1_r;
  logic       take;
  logic       last;
  logic signed [9:0] y_raw;

  assign in_stall = q_stat.full;
  assign take = in_valid && !in_stall && in_status_byte[STAT_READY_BIT]
                && in_status_byte[STAT_AUX_BIT];
  assign last = take && (pos_r == POS_LAST);

  always_comb begin
    y_raw = {{2{byte0_r[5]}}, in_data_byte};
    push_desc.move = (byte1_r != 8'd0) || (in_data_byte != 8'd0);
    push_desc.dx   = {byte0_r[4], byte1_r};
    push_desc.dy   = -y_raw;
    push_desc.chg  = byte0_r[2:0] ^ btn_r;
    push_desc.now  = byte0_r[2:0];
    push = last && (push_desc.move || (push_desc.chg != 3'd0));
  end

  always_comb begin
    pos_nxt = pos_r;
    btn_nxt = btn_r;
    if (take) begin
      if (last) begin
        pos_nxt = 2'd0;
        btn_nxt = byte0_r[2:0];
      end else begin
        pos_nxt = pos_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 2'd0;
      btn_r <= 3'd0;
    end else begin
      pos_r <= pos_nxt;
      btn_r <= btn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && pos_r == 2'd0) byte0_r <= in_data_byte;
    if (take && pos_r == 2'd1) byte1_r <= in_data_byte;
  end

  `PS2MPD_ASSERT_IMPL(a_pos_range, 1'b1, pos_r != 2'd3)

endmodule

`default_nettype wire

FILE: hw/rtl/ps2mpd_queue.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder descriptor queue
// Short register FIFO between front end and event sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ps2_mouse_packet_decoder_macros.svh"

module ps2mpd_queue
  import ps2mpd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire desc_t push_desc,
  input  wire logic  pop,
  output desc_t      pop_desc,
  output q_stat_t    q_stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign pop_desc     = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) count_nxt = count_r + CW'(1);
    if (pop && !push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_desc;
  end

  `PS2MPD_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `PS2MPD_ASSERT_IMPL(a_no_overflow, push && q_stat.full, pop)
  `PS2MPD_ASSERT_IMPL(a_no_underflow, pop, !q_stat.empty)

endmodule

`default_nettype wire

FILE: hw/rtl/ps2mpd_back.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder event sequencer
// Expands descriptors into move and button events, one a cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ps2_mouse_packet_decoder_macros.svh"

module ps2mpd_back
  import ps2mpd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire q_stat_t      q_stat,
  input  wire desc_t        pop_desc,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [1:0]        out_event_kind,
  output logic signed [8:0] out_delta_x,
  output logic signed [9:0] out_delta_y,
  output logic [1:0]        out_button_index,
  output logic              out_last_event
);

  logic [3:0] pend_r, pend_nxt;
  desc_t      cur_r;
  logic       out_valid_r;
  logic [1:0] kind_r, kind_nxt;
  logic signed [8:0] dx_r, dx_nxt;
  logic signed [9:0] dy_r, dy_nxt;
  logic [1:0] btn_r, btn_nxt;
  logic       last_r;
  logic       adv, emit;
  logic [3:0] low, rest;

  assign adv  = !out_valid_r || !out_stall;
  assign emit = adv && (pend_r != 4'd0);
  assign low  = pend_r & (~pend_r + 4'd1);
  assign rest = emit ? (pend_r & ~low) : pend_r;
  assign pop  = (rest == 4'd0) && !q_stat.empty;
  assign pend_nxt = pop ? {pop_desc.chg, pop_desc.move} : rest;

  always_comb begin
    kind_nxt = KIND_MOVE;
    dx_nxt   = '0;
    dy_nxt   = '0;
    btn_nxt  = 2'd0;
    priority if (pend_r[0]) begin
      dx_nxt = cur_r.dx;
      dy_nxt = cur_r.dy;
    end else if (pend_r[1]) begin
      kind_nxt = cur_r.now[0] ? KIND_PRESS : KIND_RELEASE;
      btn_nxt  = 2'd0;
    end else if (pend_r[2]) begin
      kind_nxt = cur_r.now[1] ? KIND_PRESS : KIND_RELEASE;
      btn_nxt  = 2'd1;
    end else begin
      kind_nxt = cur_r.now[2] ? KIND_PRESS : KIND_RELEASE;
      btn_nxt  = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (adv) out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= pop_desc;
    if (emit) begin
      kind_r <= kind_nxt;
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      btn_r  <= btn_nxt;
      last_r <= (pend_r & ~low) == 4'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = kind_r;
  assign out_delta_x      = dx_r;
  assign out_delta_y      = dy_r;
  assign out_button_index = btn_r;
  assign out_last_event   = last_r;

  `PS2MPD_ASSERT_NEXT(a_load_nonquiet, pop, pend_r != 4'd0)

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder testbench
// Drives status/data words through the valid/stall input channel, predicts
// the movement and button events of every completed packet, and compares
// each event taken from the output channel against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
  import ps2mpd_pkg::*;
();

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [8:0] dx;
    logic signed [9:0] dy;
    logic [1:0]        btn;
    logic              last;
  } mouse_event_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_status_byte;
  logic [7:0]        in_data_byte;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        out_event_kind;
  logic signed [8:0] out_delta_x;
  logic signed [9:0] out_delta_y;
  logic [1:0]        out_button_index;
  logic              out_last_event;

  mouse_event_t expected_events[$];
  logic [7:0]   held_bytes [2];
  logic [1:0]   byte_pos;
  logic [2:0]   button_bits;

  bit calm;
  int hold_request;
  int hold_left;
  int errors;
  int words_sent;
  int packets_sent;
  int events_seen;
  int moves_seen;
  int presses_seen;
  int releases_seen;

  ps2_mouse_packet_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_status_byte   (in_status_byte),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_delta_x      (out_delta_x),
    .out_delta_y      (out_delta_y),
    .out_button_index (out_button_index),
    .out_last_event   (out_last_event)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("timeout: %0d events still expected", expected_events.size());
    $display("ps2_mouse_packet_decoder regression: fail");
    $finish;
  end

  function automatic void decode_word(input logic [7:0] status, input logic [7:0] data);
    mouse_event_t pending[$];
    mouse_event_t ev;
    logic [7:0]   b0;
    logic [7:0]   b1;
    int           vx;
    int           vy;
    if (!status[STAT_READY_BIT] || !status[STAT_AUX_BIT]) return;
    if (byte_pos != POS_LAST) begin
      held_bytes[byte_pos] = data;
      byte_pos = byte_pos + 2'd1;
      return;
    end
    b0 = held_bytes[0];
    b1 = held_bytes[1];
    byte_pos = 2'd0;
    if (b1 != 8'd0 || data != 8'd0) begin
      vx = int'(b1) - (b0[4] ? 256 : 0);
      vy = -(int'(data) - (b0[5] ? 256 : 0));
      ev.kind = KIND_MOVE;
      ev.dx = vx[8:0];
      ev.dy = vy[9:0];
      ev.btn = 2'd0;
      ev.last = 1'b0;
      pending.push_back(ev);
    end
    for (int i = 0; i < 3; i++) begin
      if (b0[i] != button_bits[i]) begin
        ev.kind = b0[i] ? KIND_PRESS : KIND_RELEASE;
        ev.dx = '0;
        ev.dy = '0;
        ev.btn = 2'(i);
        ev.last = 1'b0;
        pending.push_back(ev);
      end
    end
    button_bits = b0[2:0];
    if (pending.size() > 0) pending[pending.size()-1].last = 1'b1;
    foreach (pending[k]) expected_events.push_back(pending[k]);
  endfunction

  task automatic send_word(input logic [7:0] status, input logic [7:0] data);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 17) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_status_byte <= status;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_word(status, data);
    words_sent++;
  endtask

  task automatic send_noise();
    logic [7:0] status;
    status = 8'($urandom);
    if ($urandom_range(1)) status[STAT_READY_BIT] = 1'b0;
    else status[STAT_AUX_BIT] = 1'b0;
    send_word(status, 8'($urandom));
  endtask

  task automatic send_packet(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input int noise_pct);
    logic [7:0] bytes [3];
    bytes[0] = b0;
    bytes[1] = b1;
    bytes[2] = b2;
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(99) < noise_pct) send_noise();
      send_word(8'($urandom) | 8'h21, bytes[i]);
    end
    packets_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic logic [7:0] random_delta();
    return ($urandom_range(99) < 25) ? 8'd0 : 8'($urandom);
  endfunction

  task automatic test_directed();
    send_word(8'h00, 8'hFF);
    send_word(8'h01, 8'h0F);
    send_word(8'h20, 8'hF0);
    send_word(8'hDE, 8'hAA);
    send_packet(8'h17, 8'h00, 8'h01, 0);
    send_packet(8'h20, 8'h01, 8'h00, 0);
    send_packet(8'h00, 8'h00, 8'h00, 0);
    send_packet(8'h08, 8'hFF, 8'hFF, 0);
    send_packet(8'h05, 8'h00, 8'h00, 0);
    send_noise();
    send_packet(8'h02, 8'h80, 8'h7F, 100);
    wait_drained();
  endtask

  task automatic test_random_packets();
    while (words_sent < 190) begin
      if ($urandom_range(99) < 12) send_noise();
      else send_packet(8'($urandom), random_delta(), random_delta(), 10);
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_request = 300;
    for (int i = 0; i < 8; i++) begin
      send_packet((i % 2 == 0) ? 8'h3F : 8'hC0, 8'($urandom) | 8'h01, 8'($urandom), 0);
    end
    wait_drained();
  endtask

  task automatic test_calm_stream();
    calm = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_packet(8'($urandom), random_delta(), random_delta(), 0);
    end
    wait_drained();
    calm = 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 17);
    end
  end

  always @(posedge clk) begin
    mouse_event_t want;
    mouse_event_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind = out_event_kind;
      got.dx = out_delta_x;
      got.dy = out_delta_y;
      got.btn = out_button_index;
      got.last = out_last_event;
      events_seen++;
      case (got.kind)
        KIND_MOVE:  moves_seen++;
        KIND_PRESS: presses_seen++;
        default:    releases_seen++;
      endcase
      if (expected_events.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected event: kind=%0d dx=%0d dy=%0d btn=%0d last=%0b",
                   got.kind, got.dx, got.dy, got.btn, got.last);
      end else begin
        want = expected_events.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display("event mismatch: expected kind=%0d dx=%0d dy=%0d btn=%0d last=%0b, %s",
                     want.kind, want.dx, want.dy, want.btn, want.last,
                     $sformatf("got kind=%0d dx=%0d dy=%0d btn=%0d last=%0b",
                               got.kind, got.dx, got.dy, got.btn, got.last));
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_status_byte = 8'd0;
    in_data_byte = 8'd0;
    out_stall = 1'b0;
    calm = 1'b0;
    hold_request = 0;
    hold_left = 0;
    errors = 0;
    words_sent = 0;
    packets_sent = 0;
    events_seen = 0;
    moves_seen = 0;
    presses_seen = 0;
    releases_seen = 0;
    held_bytes[0] = 8'd0;
    held_bytes[1] = 8'd0;
    byte_pos = 2'd0;
    button_bits = 3'd0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_packets();
    test_backpressure();
    test_calm_stream();

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    if (expected_events.size() != 0) errors += expected_events.size();

    $display("sent %0d words in %0d packets plus rejected words, with a long output hold-off",
             words_sent, packets_sent);
    $display("checked %0d events: %0d moves, %0d presses, %0d releases, %0d mismatches",
             events_seen, moves_seen, presses_seen, releases_seen, errors);
    if (errors == 0) begin
      $display("ps2_mouse_packet_decoder regression: pass");
    end else begin
      $display("ps2_mouse_packet_decoder regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: ps2_mouse_packet_decoder.f
+incdir+hw/rtl
hw/rtl/ps2mpd_pkg.sv
hw/rtl/ps2mpd_front.sv
hw/rtl/ps2mpd_queue.sv
hw/rtl/ps2mpd_back.sv
hw/rtl/ps2_mouse_packet_decoder.sv
verif/tb_top.sv
